// ===== rtl/atac_pkg.sv =====
`default_nettype none

package atac_pkg;

	localparam int DistW    = 14;
	localparam int TimeW    = 32;
	localparam int SecW     = 16;
	localparam int MsPerSec = 1000;
	// 65535 s * 1000 ms/s fits in 26 bits.
	localparam int SecMsW   = 26;
	localparam int AddrW    = 5;
	localparam int DataW    = 32;
	localparam int RegIdxW  = 3;

	localparam logic [DistW-1:0]  ThresholdRst     = DistW'(50);
	localparam logic [SecW-1:0]   ShortBreakRst    = SecW'(120);
	localparam logic [SecW-1:0]   WarningRst       = SecW'(300);
	localparam logic [TimeW-1:0]  WarnPeriodRst    = TimeW'(30000);
	localparam logic [TimeW-1:0]  DistractPerRst   = TimeW'(30000);
	localparam logic [TimeW-1:0]  FlashIntervalRst = TimeW'(250);

	typedef enum logic [RegIdxW-1:0] {
		REG_THRESHOLD      = 3'd0,
		REG_SHORT_BREAK    = 3'd1,
		REG_WARNING        = 3'd2,
		REG_WARN_PERIOD    = 3'd3,
		REG_DISTRACT_PER   = 3'd4,
		REG_FLASH_INTERVAL = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_FOCUS       = 2'd0,
		ST_SHORT_BREAK = 2'd1,
		ST_WARNING     = 2'd2,
		ST_DISTRACTED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BEEP_NONE   = 2'd0,
		BEEP_SHORT  = 2'd1,
		BEEP_TRIPLE = 2'd2
	} beep_t;

	typedef struct packed {
		logic [DistW-1:0]  threshold_cm;
		logic [SecMsW-1:0] short_break_ms;
		logic [SecMsW-1:0] warning_ms;
		logic [TimeW-1:0]  warn_period_ms;
		logic [TimeW-1:0]  distract_period_ms;
		logic [TimeW-1:0]  flash_interval_ms;
	} cfg_t;

	typedef struct packed {
		status_t status;
		logic    led_write;
		logic    led_red;
		logic    led_green;
		logic    led_blue;
		beep_t   beep;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/absence_timer_alert_controller.sv =====
// Absence timer alert controller. Each input beat carries one distance
// reading and a millisecond timestamp and produces exactly one result beat
// with the status, LED drive and beep request. A beat can be accepted on
// every clock while in_stall is low; the input register takes it at the
// accepting edge and the decision logic feeds the result register when
// the beat advances, which a result-side stall can hold off. Throughput
// is one beat per cycle as long as the result side does not stall.
// Thresholds in seconds are converted to milliseconds when they are
// written over the register port, so the datapath needs no divider. The
// registers should only be written while no beat is in flight.
`default_nettype none

module absence_timer_alert_controller
	import atac_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output logic                  pready,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [DistW-1:0] distance_cm,
	input  wire logic [TimeW-1:0] now_ms,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [1:0]       status,
	output logic                  led_write,
	output logic                  led_red,
	output logic                  led_green,
	output logic                  led_blue,
	output logic      [1:0]       beep
);

	cfg_t             cfg;
	res_t             res;
	res_t             res_q;
	logic             valid_s1;
	logic [DistW-1:0] dist_s1;
	logic [TimeW-1:0] now_s1;
	logic             out_valid_q;
	logic             advance;
	logic             in_take;

	atac_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	atac_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.step_en  (advance),
		.distance (dist_s1),
		.now      (now_s1),
		.res      (res)
	);

	// The stage-one beat moves on whenever the result register is empty or
	// being drained, so a fresh input beat is held off only while both
	// registers are full and the result side stalls.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			dist_s1 <= distance_cm;
			now_s1  <= now_ms;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign led_write = res_q.led_write;
	assign led_red   = res_q.led_red;
	assign led_green = res_q.led_green;
	assign led_blue  = res_q.led_blue;
	assign beep      = res_q.beep;

`ifndef ASSERT_OFF
	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room in the pipeline");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register empty after a beat advanced");

	a_dark_only_distracted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.led_write |-> res_q.status == ST_DISTRACTED)
		else $error("LED left undriven outside distracted status");
`endif

endmodule

`default_nettype wire

// ===== rtl/atac_cfg.sv =====
`default_nettype none

module atac_cfg
	import atac_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [DistW-1:0]  threshold_q;
	logic [SecW-1:0]   short_break_q;
	logic [SecW-1:0]   warning_q;
	logic [SecMsW-1:0] short_break_ms_q;
	logic [SecMsW-1:0] warning_ms_q;
	logic [TimeW-1:0]  warn_period_q;
	logic [TimeW-1:0]  distract_period_q;
	logic [TimeW-1:0]  flash_interval_q;
	logic              wr_en;
	reg_idx_t          idx;
	logic [SecMsW-1:0] wdata_ms;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);

	// Second thresholds are kept in milliseconds as well, so the datapath
	// compares elapsed milliseconds directly instead of dividing by 1000.
	assign wdata_ms = SecMsW'(pwdata[SecW-1:0]) * SecMsW'(MsPerSec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q       <= ThresholdRst;
			short_break_q     <= ShortBreakRst;
			warning_q         <= WarningRst;
			short_break_ms_q  <= SecMsW'(ShortBreakRst) * SecMsW'(MsPerSec);
			warning_ms_q      <= SecMsW'(WarningRst) * SecMsW'(MsPerSec);
			warn_period_q     <= WarnPeriodRst;
			distract_period_q <= DistractPerRst;
			flash_interval_q  <= FlashIntervalRst;
		end else if (wr_en) begin
			case (idx)
				REG_THRESHOLD: begin
					threshold_q <= pwdata[DistW-1:0];
				end
				REG_SHORT_BREAK: begin
					short_break_q    <= pwdata[SecW-1:0];
					short_break_ms_q <= wdata_ms;
				end
				REG_WARNING: begin
					warning_q    <= pwdata[SecW-1:0];
					warning_ms_q <= wdata_ms;
				end
				REG_WARN_PERIOD: begin
					warn_period_q <= pwdata[TimeW-1:0];
				end
				REG_DISTRACT_PER: begin
					distract_period_q <= pwdata[TimeW-1:0];
				end
				REG_FLASH_INTERVAL: begin
					flash_interval_q <= pwdata[TimeW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_THRESHOLD:      prdata = DataW'(threshold_q);
			REG_SHORT_BREAK:    prdata = DataW'(short_break_q);
			REG_WARNING:        prdata = DataW'(warning_q);
			REG_WARN_PERIOD:    prdata = DataW'(warn_period_q);
			REG_DISTRACT_PER:   prdata = DataW'(distract_period_q);
			REG_FLASH_INTERVAL: prdata = DataW'(flash_interval_q);
			default:            prdata = '0;
		endcase
	end

	assign cfg.threshold_cm       = threshold_q;
	assign cfg.short_break_ms     = short_break_ms_q;
	assign cfg.warning_ms         = warning_ms_q;
	assign cfg.warn_period_ms     = warn_period_q;
	assign cfg.distract_period_ms = distract_period_q;
	assign cfg.flash_interval_ms  = flash_interval_q;

endmodule

`default_nettype wire

// ===== rtl/atac_core.sv =====
`default_nettype none

module atac_core
	import atac_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             step_en,
	input  wire logic [DistW-1:0] distance,
	input  wire logic [TimeW-1:0] now,
	output res_t                  res
);

	logic [TimeW-1:0] away_start_q;
	logic [TimeW-1:0] last_flash_q;
	logic [TimeW-1:0] last_warn_q;
	logic [TimeW-1:0] last_triple_q;
	logic             flash_level_q;
	logic             long_flag_q;

	logic [TimeW-1:0] away_ms;
	logic [TimeW-1:0] since_warn;
	logic [TimeW-1:0] since_triple;
	logic [TimeW-1:0] since_flash;
	logic             present;
	logic             in_short;
	logic             in_warning;
	logic             warn_due;
	logic             triple_due;
	logic             flash_due;

	// All differences wrap modulo 2^32 by construction.
	assign away_ms      = now - away_start_q;
	assign since_warn   = now - last_warn_q;
	assign since_triple = now - last_triple_q;
	assign since_flash  = now - last_flash_q;

	assign present    = distance < cfg.threshold_cm;
	// floor(ms / 1000) < s holds exactly when ms < s * 1000.
	assign in_short   = away_ms < TimeW'(cfg.short_break_ms);
	assign in_warning = away_ms < TimeW'(cfg.warning_ms);
	assign warn_due   = since_warn >= cfg.warn_period_ms;
	assign triple_due = since_triple >= cfg.distract_period_ms;
	assign flash_due  = since_flash >= cfg.flash_interval_ms;

	always_comb begin
		res = '{status: ST_FOCUS, led_write: 1'b0, led_red: 1'b0, led_green: 1'b0,
			led_blue: 1'b0, beep: BEEP_NONE};
		if (present) begin
			res.status    = ST_FOCUS;
			res.led_write = 1'b1;
			res.led_green = 1'b1;
			if (long_flag_q) begin
				res.beep = BEEP_SHORT;
			end
		end else if (in_short) begin
			res.status    = ST_SHORT_BREAK;
			res.led_write = 1'b1;
			res.led_green = 1'b1;
		end else if (in_warning) begin
			res.status    = ST_WARNING;
			res.led_write = 1'b1;
			res.led_blue  = 1'b1;
			if (warn_due) begin
				res.beep = BEEP_SHORT;
			end
		end else begin
			res.status = ST_DISTRACTED;
			if (triple_due) begin
				res.beep = BEEP_TRIPLE;
			end
			// The red LED shows the level after the toggle.
			if (flash_due) begin
				res.led_write = 1'b1;
				res.led_red   = !flash_level_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			away_start_q  <= '0;
			last_flash_q  <= '0;
			last_warn_q   <= '0;
			last_triple_q <= '0;
			flash_level_q <= 1'b0;
			long_flag_q   <= 1'b0;
		end else if (step_en) begin
			if (present) begin
				away_start_q <= now;
				long_flag_q  <= 1'b0;
			end else if (in_short) begin
			end else if (in_warning) begin
				if (warn_due) begin
					last_warn_q <= now;
				end
			end else begin
				long_flag_q <= 1'b1;
				if (triple_due) begin
					last_triple_q <= now;
				end
				if (flash_due) begin
					last_flash_q  <= now;
					flash_level_q <= !flash_level_q;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_focus_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.status == ST_FOCUS |=> !long_flag_q)
		else $error("long absence flag survived a focus beat");

	a_distracted_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.status == ST_DISTRACTED |=> long_flag_q)
		else $error("long absence flag not set after distracted beat");

	a_triple_only_distracted: assert property (@(posedge clk) disable iff (!arst_n)
		res.beep == BEEP_TRIPLE |-> res.status == ST_DISTRACTED)
		else $error("triple beep outside distracted status");

	a_flash_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.status == ST_DISTRACTED && res.led_write |=>
		flash_level_q != $past(flash_level_q))
		else $error("red LED written without flash level toggle");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_absence_timer_alert_controller.sv =====
`default_nettype none

module tb_absence_timer_alert_controller;
	import atac_pkg::*;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned PrintCap   = 100;
	localparam logic [AddrW-1:0] SpareAddr = AddrW'(24);

	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	typedef struct {
		logic [DistW-1:0] dist_cm;
		logic [TimeW-1:0] stamp;
		bit               typed;
		res_t             want;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;
	logic             in_valid;
	logic             in_stall;
	logic [DistW-1:0] distance_cm;
	logic [TimeW-1:0] now_ms;
	logic             out_valid;
	logic             out_stall;
	logic [1:0]       status;
	logic             led_write;
	logic             led_red;
	logic             led_green;
	logic             led_blue;
	logic [1:0]       beep;

	// Register copies kept by the predictor.
	logic [DistW-1:0] thr_cm;
	logic [SecW-1:0]  short_s;
	logic [SecW-1:0]  warn_s;
	logic [TimeW-1:0] warn_per_ms;
	logic [TimeW-1:0] distract_per_ms;
	logic [TimeW-1:0] flash_ms;

	// Tracker state.
	logic [TimeW-1:0] away_start;
	logic [TimeW-1:0] last_flash;
	logic             flash_on;
	logic [TimeW-1:0] last_warn_beep;
	logic [TimeW-1:0] last_triple_beep;
	logic             long_absent;

	res_t             pending_alerts[$];
	int unsigned      mismatches;
	int unsigned      beats_seen;
	int unsigned      cyc_cnt;
	logic [TimeW-1:0] wall_ms;

	int unsigned      hold_left;
	bit               hold_done;
	rx_mode_t         rx_mode;
	int unsigned      rx_mode_left;

	dir_row_t dir_rows [0:14] = '{
		'{14'd0,     32'd0,          1'b1, '{ST_FOCUS,       1'b1, 1'b0, 1'b1, 1'b0, BEEP_NONE}},
		'{14'd16383, 32'd1000,       1'b1, '{ST_SHORT_BREAK, 1'b1, 1'b0, 1'b1, 1'b0, BEEP_NONE}},
		'{14'd50,    32'd119999,     1'b1, '{ST_SHORT_BREAK, 1'b1, 1'b0, 1'b1, 1'b0, BEEP_NONE}},
		'{14'd9999,  32'd120000,     1'b1, '{ST_WARNING,     1'b1, 1'b0, 1'b0, 1'b1, BEEP_SHORT}},
		'{14'd9999,  32'd130000,     1'b0, '{ST_FOCUS,       1'b0, 1'b0, 1'b0, 1'b0, BEEP_NONE}},
		'{14'd9999,  32'd300000,     1'b1, '{ST_DISTRACTED,  1'b1, 1'b1, 1'b0, 1'b0, BEEP_TRIPLE}},
		'{14'd9999,  32'd300100,     1'b1, '{ST_DISTRACTED,  1'b0, 1'b0, 1'b0, 1'b0, BEEP_NONE}},
		'{14'd9999,  32'd300250,     1'b1, '{ST_DISTRACTED,  1'b1, 1'b0, 1'b0, 1'b0, BEEP_NONE}},
		'{14'd49,    32'd300300,     1'b1, '{ST_FOCUS,       1'b1, 1'b0, 1'b1, 1'b0, BEEP_SHORT}},
		'{14'd49,    32'd300400,     1'b0, '{ST_FOCUS,       1'b0, 1'b0, 1'b0, 1'b0, BEEP_NONE}},
		'{14'd0,     32'hFFFFFF00,   1'b1, '{ST_FOCUS,       1'b1, 1'b0, 1'b1, 1'b0, BEEP_NONE}},
		'{14'd100,   32'h00000200,   1'b1, '{ST_SHORT_BREAK, 1'b1, 1'b0, 1'b1, 1'b0, BEEP_NONE}},
		'{14'd100,   32'hFFFFFEFF,   1'b1, '{ST_DISTRACTED,  1'b1, 1'b1, 1'b0, 1'b0, BEEP_TRIPLE}},
		'{14'd0,     32'hFFFFFF10,   1'b1, '{ST_FOCUS,       1'b1, 1'b0, 1'b1, 1'b0, BEEP_SHORT}},
		'{14'd16382, 32'd5,          1'b0, '{ST_FOCUS,       1'b0, 1'b0, 1'b0, 1'b0, BEEP_NONE}}
	};

	absence_timer_alert_controller u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.distance_cm (distance_cm),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.led_write   (led_write),
		.led_red     (led_red),
		.led_green   (led_green),
		.led_blue    (led_blue),
		.beep        (beep)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic res_t predict_alert(input logic [DistW-1:0] d,
			input logic [TimeW-1:0] t);
		res_t             r;
		logic [TimeW-1:0] gap_ms;
		logic [TimeW-1:0] away_s;
		r = '0;
		if (d < thr_cm) begin
			if (long_absent) begin
				r.beep = BEEP_SHORT;
				long_absent = 1'b0;
			end
			away_start = t;
			r.status = ST_FOCUS;
			r.led_write = 1'b1;
			r.led_green = 1'b1;
		end else begin
			gap_ms = t - away_start;
			away_s = gap_ms / TimeW'(MsPerSec);
			if (away_s < TimeW'(short_s)) begin
				r.status = ST_SHORT_BREAK;
				r.led_write = 1'b1;
				r.led_green = 1'b1;
			end else if (away_s < TimeW'(warn_s)) begin
				r.status = ST_WARNING;
				r.led_write = 1'b1;
				r.led_blue = 1'b1;
				if (TimeW'(t - last_warn_beep) >= warn_per_ms) begin
					r.beep = BEEP_SHORT;
					last_warn_beep = t;
				end
			end else begin
				r.status = ST_DISTRACTED;
				if (TimeW'(t - last_triple_beep) >= distract_per_ms) begin
					r.beep = BEEP_TRIPLE;
					last_triple_beep = t;
				end
				// The LED is left alone unless a toggle is due.
				if (TimeW'(t - last_flash) >= flash_ms) begin
					last_flash = t;
					flash_on = ~flash_on;
					r.led_write = 1'b1;
					r.led_red = flash_on;
				end
				long_absent = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		if (mismatches <= PrintCap)
			$display("MISMATCH at beat %0d, %s: got %0d, want %0d", beats_seen, what, got, want);
	endtask

	task automatic cfg_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (addr[AddrW-1:2])
			REG_THRESHOLD:      thr_cm = val[DistW-1:0];
			REG_SHORT_BREAK:    short_s = val[SecW-1:0];
			REG_WARNING:        warn_s = val[SecW-1:0];
			REG_WARN_PERIOD:    warn_per_ms = val;
			REG_DISTRACT_PER:   distract_per_ms = val;
			REG_FLASH_INTERVAL: flash_ms = val;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_settings(input logic [DataW-1:0] thr, input logic [DataW-1:0] sb,
			input logic [DataW-1:0] wn, input logic [DataW-1:0] wp,
			input logic [DataW-1:0] dp, input logic [DataW-1:0] fl);
		cfg_write(AddrW'(4 * REG_THRESHOLD), thr);
		cfg_write(AddrW'(4 * REG_SHORT_BREAK), sb);
		cfg_write(AddrW'(4 * REG_WARNING), wn);
		cfg_write(AddrW'(4 * REG_WARN_PERIOD), wp);
		cfg_write(AddrW'(4 * REG_DISTRACT_PER), dp);
		cfg_write(AddrW'(4 * REG_FLASH_INTERVAL), fl);
	endtask

	task automatic send_beat(input logic [DistW-1:0] d, input logic [TimeW-1:0] t,
			input bit typed, input res_t want);
		res_t pred;
		@(negedge clk);
		in_valid <= 1'b1;
		distance_cm <= d;
		now_ms <= t;
		do @(posedge clk); while (in_stall);
		pred = predict_alert(d, t);
		pending_alerts.push_back(typed ? want : pred);
	endtask

	task automatic idle_gap(input int unsigned n);
		if (n != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain(input int unsigned tail);
		while (pending_alerts.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned      burst_left;
		int unsigned      run_left;
		bit               here;
		logic [DistW-1:0] d;
		burst_left = 0;
		run_left = 0;
		here = 1'b0;
		for (int unsigned k = 0; k < count; k++) begin
			if (burst_left == 0) begin
				idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
			// Presence comes in runs so that long absences build up.
			if (run_left == 0) begin
				here = ($urandom_range(0, 2) == 0);
				run_left = here ? $urandom_range(1, 8) : $urandom_range(1, 60);
			end
			run_left--;
			if ($urandom_range(0, 9) == 0) begin
				d = DistW'($urandom);
			end else if (here && thr_cm != 0) begin
				case ($urandom_range(0, 3))
					0: d = thr_cm - 1'b1;
					1: d = '0;
					default: d = DistW'($urandom_range(0, thr_cm - 1));
				endcase
			end else begin
				case ($urandom_range(0, 4))
					0: d = thr_cm;
					1: d = '1;
					2: d = DistW'(9999);
					default: d = DistW'($urandom_range(thr_cm, 16383));
				endcase
			end
			case ($urandom_range(0, 19))
				0: wall_ms = $urandom;
				1: ;
				2, 3, 4: wall_ms = wall_ms + $urandom_range(0, 400);
				default: wall_ms = wall_ms + $urandom_range(100, 3000);
			endcase
			send_beat(d, wall_ms, 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		distance_cm = '0;
		now_ms = '0;
		out_stall = 1'b0;
		thr_cm = ThresholdRst;
		short_s = ShortBreakRst;
		warn_s = WarningRst;
		warn_per_ms = WarnPeriodRst;
		distract_per_ms = DistractPerRst;
		flash_ms = FlashIntervalRst;
		away_start = '0;
		last_flash = '0;
		flash_on = 1'b0;
		last_warn_beep = '0;
		last_triple_beep = '0;
		long_absent = 1'b0;
		mismatches = 0;
		wall_ms = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 15; i++)
			send_beat(dir_rows[i].dist_cm, dir_rows[i].stamp, dir_rows[i].typed,
				dir_rows[i].want);
		wall_ms = dir_rows[14].stamp;

		for (int ph = 1; ph < 10; ph++) begin
			idle_gap(1);
			drain(4);
			case (ph)
				// Nobody is ever present, every tick beeps and toggles.
				1: load_settings('0, '0, '0, '0, '0, '0);
				// All ones: registers narrower than the bus keep only their low bits.
				2: load_settings('1, '1, '1, '1, '1, '1);
				// Warning window left empty by a warning limit below the short break.
				3: load_settings(120, 10, 5, 2000, 3000, 400);
				9: load_settings(10000, 1, 2, 1, 1, 1);
				default: load_settings($urandom_range(0, 400), $urandom_range(0, 8),
					$urandom_range(0, 20), $urandom_range(0, 8000),
					$urandom_range(0, 8000), $urandom_range(0, 1500));
			endcase
			if (ph == 4)
				cfg_write(SpareAddr, $urandom);
			run_random(120);
		end

		idle_gap(1);
		drain(8);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin : check_alerts
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_alerts.size() == 0) begin
				flag_mismatch("beat with nothing pending", 1, 0);
			end else begin
				want = pending_alerts.pop_front();
				if (status !== want.status) flag_mismatch("status", status, want.status);
				if (led_write !== want.led_write)
					flag_mismatch("led_write", led_write, want.led_write);
				if (led_red !== want.led_red) flag_mismatch("led_red", led_red, want.led_red);
				if (led_green !== want.led_green)
					flag_mismatch("led_green", led_green, want.led_green);
				if (led_blue !== want.led_blue) flag_mismatch("led_blue", led_blue, want.led_blue);
				if (beep !== want.beep) flag_mismatch("beep", beep, want.beep);
			end
			beats_seen++;
		end
	end

	// Receiver: changing stall patterns, plus one long hold-off that backs up the block.
	always @(negedge clk) begin
		if (!hold_done && beats_seen >= 500) begin
			hold_done = 1'b1;
			hold_left = 300;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(16, 96);
			end
			rx_mode_left--;
			case (rx_mode)
				RX_FREE:   out_stall <= 1'b0;
				RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
				default:   out_stall <= (cyc_cnt % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cyc_cnt++;
		if (cyc_cnt == CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		beats_seen = 0;
		cyc_cnt = 0;
		hold_left = 0;
		hold_done = 1'b0;
		rx_mode = RX_FREE;
		rx_mode_left = 0;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/atac_pkg.sv
rtl/atac_cfg.sv
rtl/atac_core.sv
rtl/absence_timer_alert_controller.sv
tb/tb_absence_timer_alert_controller.sv
